// File: rtl/ssrk_pkg.sv
package ssrk_pkg;

   localparam int MAX_STATES  = 8;
   localparam int MAX_INPUTS  = 4;
   localparam int MAX_OUTPUTS = 4;

   localparam int BASE_B      = MAX_STATES * MAX_STATES;
   localparam int BASE_C      = BASE_B + MAX_STATES * MAX_INPUTS;
   localparam int BASE_D      = BASE_C + MAX_OUTPUTS * MAX_STATES;
   localparam int STORE_DEPTH = BASE_D + MAX_OUTPUTS * MAX_INPUTS;

   localparam int ADDR_W = 8;
   localparam int ROW_W  = 3;
   localparam int TERM_W = 4;

   // floor(a/3) = (a * RECIP3) >> 33 for any 32-bit a
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

   typedef enum logic [1:0] {
      FUNC_LOAD_COEF  = 2'd0,
      FUNC_LOAD_STATE = 2'd1,
      FUNC_OUTPUT     = 2'd2,
      FUNC_STEP       = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_STATES_USED  = 2'd0,
      CSR_INPUTS_USED  = 2'd1,
      CSR_OUTPUTS_USED = 2'd2,
      CSR_STEP_SIZE    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TERM,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_OUT,
      ST_HMUL,
      ST_HRES,
      ST_KUPD,
      ST_KSUM,
      ST_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      logic              accept;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              opd_u;
      logic [ROW_W-1:0]  opd_idx;
      logic              acc_clr;
      logic              mul_h;
      logic              k_load;
      logic              k_upd;
      logic              k_sum;
      logic [1:0]        stage;
      logic [ROW_W-1:0]  row;
      logic              xs_copy;
      logic              x_commit;
      logic              rsp_load;
      logic              rsp_last;
   } dp_cmd_type;

   typedef struct packed {
      logic [3:0] nx;
      logic [2:0] ni;
      logic [2:0] no;
      logic       rsp_busy;
   } dp_status_type;

endpackage

// File: rtl/ssrk_ctrl.sv
module ssrk_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_func,
   output logic                     req_stall,
   input  ssrk_pkg::dp_status_type  status,
   output ssrk_pkg::dp_cmd_type     cmd
);

   ssrk_pkg::ctrl_state_type state_ff, state_in;
   logic [ssrk_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [ssrk_pkg::TERM_W-1:0] term_ff, term_in;
   logic [1:0]                  stage_ff, stage_in;
   logic                        step_ff, step_in;

   logic [3:0]                  nrows;
   logic                        last_row;
   logic                        last_term;
   logic                        term_is_u;
   logic [ssrk_pkg::ROW_W-1:0]  uidx;
   logic [ssrk_pkg::ADDR_W-1:0] row_x_base, row_u_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssrk_pkg::ST_IDLE;
         row_ff   <= '0;
         term_ff  <= '0;
         stage_ff <= '0;
         step_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         term_ff  <= term_in;
         stage_ff <= stage_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      nrows     = step_ff ? status.nx : {1'b0, status.no};
      last_row  = (4'(row_ff) + 4'd1) == nrows;
      last_term = (5'(term_ff) + 5'd1) == (5'(status.nx) + 5'(status.ni));
      term_is_u = 5'(term_ff) >= 5'(status.nx);
      uidx      = ssrk_pkg::ROW_W'(term_ff - ssrk_pkg::TERM_W'(status.nx));
      if (step_ff) begin
         row_x_base = ssrk_pkg::ADDR_W'(row_ff) * ssrk_pkg::ADDR_W'(ssrk_pkg::MAX_STATES);
         row_u_base = ssrk_pkg::ADDR_W'(ssrk_pkg::BASE_B)
                      + ssrk_pkg::ADDR_W'(row_ff) * ssrk_pkg::ADDR_W'(ssrk_pkg::MAX_INPUTS);
      end else begin
         row_x_base = ssrk_pkg::ADDR_W'(ssrk_pkg::BASE_C)
                      + ssrk_pkg::ADDR_W'(row_ff) * ssrk_pkg::ADDR_W'(ssrk_pkg::MAX_STATES);
         row_u_base = ssrk_pkg::ADDR_W'(ssrk_pkg::BASE_D)
                      + ssrk_pkg::ADDR_W'(row_ff) * ssrk_pkg::ADDR_W'(ssrk_pkg::MAX_INPUTS);
      end
   end

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      term_in   = term_ff;
      stage_in  = stage_ff;
      step_in   = step_ff;
      req_stall = 1'b1;

      cmd          = '0;
      cmd.stage    = stage_ff;
      cmd.row      = row_ff;
      cmd.opd_u    = term_is_u;
      cmd.opd_idx  = term_is_u ? uidx : ssrk_pkg::ROW_W'(term_ff);
      cmd.rd_addr  = term_is_u ? row_u_base + ssrk_pkg::ADDR_W'(uidx)
                               : row_x_base + ssrk_pkg::ADDR_W'(term_ff);
      cmd.rsp_last = last_row;

      unique case (state_ff)
         ssrk_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               row_in     = '0;
               term_in    = '0;
               stage_in   = '0;
               if (req_func == ssrk_pkg::FUNC_OUTPUT || req_func == ssrk_pkg::FUNC_STEP) begin
                  step_in  = req_func == ssrk_pkg::FUNC_STEP;
                  state_in = ssrk_pkg::ST_TERM;
               end
            end
         end
         ssrk_pkg::ST_TERM: begin
            cmd.rd_en   = 1'b1;
            cmd.acc_clr = term_ff == '0;
            term_in     = term_ff + 1'b1;
            if (last_term) begin
               term_in  = '0;
               state_in = ssrk_pkg::ST_DRAIN1;
            end
         end
         ssrk_pkg::ST_DRAIN1: state_in = ssrk_pkg::ST_DRAIN2;
         ssrk_pkg::ST_DRAIN2: state_in = step_ff ? ssrk_pkg::ST_HMUL : ssrk_pkg::ST_OUT;
         ssrk_pkg::ST_OUT: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               if (last_row) begin
                  state_in = ssrk_pkg::ST_IDLE;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = ssrk_pkg::ST_TERM;
               end
            end
         end
         ssrk_pkg::ST_HMUL: begin
            cmd.mul_h = 1'b1;
            state_in  = ssrk_pkg::ST_HRES;
         end
         ssrk_pkg::ST_HRES: begin
            cmd.k_load = 1'b1;
            state_in   = ssrk_pkg::ST_KUPD;
         end
         ssrk_pkg::ST_KUPD: begin
            cmd.k_upd = 1'b1;
            state_in  = ssrk_pkg::ST_KSUM;
         end
         ssrk_pkg::ST_KSUM: begin
            cmd.k_sum = 1'b1;
            if (last_row) begin
               row_in = '0;
               if (stage_ff == 2'd3) begin
                  state_in = ssrk_pkg::ST_COMMIT;
               end else begin
                  cmd.xs_copy = 1'b1;
                  stage_in    = stage_ff + 1'b1;
                  state_in    = ssrk_pkg::ST_TERM;
               end
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = ssrk_pkg::ST_TERM;
            end
         end
         ssrk_pkg::ST_COMMIT: begin
            cmd.x_commit = 1'b1;
            state_in     = ssrk_pkg::ST_IDLE;
         end
         default: state_in = ssrk_pkg::ST_IDLE;
      endcase
   end

endmodule

// File: rtl/ssrk_dp.sv
module ssrk_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  ssrk_pkg::dp_cmd_type     cmd,
   output ssrk_pkg::dp_status_type  status,
   input  logic [1:0]               req_func,
   input  logic [7:0]               req_address,
   input  logic signed [31:0]       req_value,
   input  logic signed [31:0]       req_u_zero,
   input  logic signed [31:0]       req_u_one,
   input  logic signed [31:0]       req_u_two,
   input  logic signed [31:0]       req_u_three,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [30:0]              csr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_out_index,
   output logic signed [31:0]       rsp_out_value,
   output logic                     rsp_out_last
);

   localparam int NS = ssrk_pkg::MAX_STATES;
   localparam int NI = ssrk_pkg::MAX_INPUTS;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)
         return 32'sh7FFF_FFFF;
      else if (v < -64'sd2147483648)
         return 32'sh8000_0000;
      else
         return v[31:0];
   endfunction

   logic [3:0]  states_ff;
   logic [2:0]  inputs_ff;
   logic [2:0]  outputs_ff;
   logic [30:0] h_ff;

   logic [31:0]        mem [ssrk_pkg::STORE_DEPTH];
   logic signed [31:0] memq_ff;
   logic               v1_ff, v2_ff;
   logic               opu_ff;
   logic [ssrk_pkg::ROW_W-1:0] opi_ff;

   logic signed [31:0] x0_ff [NS];
   logic signed [31:0] xs_ff [NS];
   logic signed [31:0] xn_ff [NS];
   logic signed [34:0] ks_ff [NS];
   logic signed [31:0] u_ff  [NI];

   logic signed [63:0] prod_ff;
   logic signed [51:0] acc_ff;
   logic signed [31:0] k_ff;
   logic [63:0]        rq_ff;
   logic               ksign_ff;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_index_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_last_ff;

   logic signed [31:0] opd;
   logic signed [31:0] d_sat;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] product;
   logic signed [31:0] k_add;
   logic [32:0]        k_neg;
   logic [31:0]        k_mag;
   logic [30:0]        q3, qm;
   logic signed [34:0] qs;

   // clamped sizes
   always_comb begin
      status.nx = (states_ff == '0) ? 4'd1 :
                  (states_ff > 4'(NS)) ? 4'(NS) : states_ff;
      status.ni = (inputs_ff == '0) ? 3'd1 :
                  (inputs_ff > 3'(NI)) ? 3'(NI) : inputs_ff;
      status.no = (outputs_ff == '0) ? 3'd1 :
                  (outputs_ff > 3'(ssrk_pkg::MAX_OUTPUTS)) ? 3'(ssrk_pkg::MAX_OUTPUTS)
                                                             : outputs_ff;
      status.rsp_busy = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         states_ff  <= 4'd1;
         inputs_ff  <= 3'd1;
         outputs_ff <= 3'd1;
         h_ff       <= 31'd655;
      end else if (csr_write) begin
         unique case (csr_index)
            ssrk_pkg::CSR_STATES_USED:  states_ff  <= csr_data[3:0];
            ssrk_pkg::CSR_INPUTS_USED:  inputs_ff  <= csr_data[2:0];
            ssrk_pkg::CSR_OUTPUTS_USED: outputs_ff <= csr_data[2:0];
            ssrk_pkg::CSR_STEP_SIZE:    h_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   // coefficient store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.accept && req_func == ssrk_pkg::FUNC_LOAD_COEF
          && 32'(req_address) < ssrk_pkg::STORE_DEPTH)
         mem[req_address] <= req_value;
      if (cmd.rd_en)
         memq_ff <= mem[cmd.rd_addr];
   end

   always_comb begin
      opd     = opu_ff ? u_ff[opi_ff[1:0]] : xs_ff[opi_ff];
      d_sat   = sat32(64'(acc_ff));
      mul_a   = cmd.mul_h ? {2'b00, h_ff} : {memq_ff[31], memq_ff};
      mul_b   = cmd.mul_h ? {d_sat[31], d_sat} : {opd[31], opd};
      product = mul_a * mul_b;
      k_add   = (cmd.stage < 2'd2) ? (k_ff >>> 1) : k_ff;
      k_neg   = -{k_ff[31], k_ff};
      k_mag   = k_ff[31] ? k_neg[31:0] : k_ff;
      q3      = rq_ff[63:33];
      qm      = (cmd.stage == 2'd0 || cmd.stage == 2'd3) ? (q3 >> 1) : q3;
      qs      = ksign_ff ? -$signed({4'b0, qm}) : $signed({4'b0, qm});
   end

   // MAC pipeline: read, multiply, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.rd_en;
         v2_ff <= v1_ff;
      end
      opu_ff <= cmd.opd_u;
      opi_ff <= cmd.opd_idx;
      if (v1_ff || cmd.mul_h)
         prod_ff <= product[63:0];
      if (cmd.acc_clr)
         acc_ff <= '0;
      else if (v2_ff)
         acc_ff <= acc_ff + 52'(prod_ff >>> 16);
      if (cmd.k_load)
         k_ff <= sat32(prod_ff >>> 16);
      if (cmd.k_upd) begin
         xn_ff[cmd.row] <= sat32(64'(x0_ff[cmd.row]) + 64'(k_add));
         rq_ff          <= k_mag * ssrk_pkg::RECIP3;
         ksign_ff       <= k_ff[31];
      end
      if (cmd.k_sum)
         ks_ff[cmd.row] <= ((cmd.stage == 2'd0) ? 35'sd0 : ks_ff[cmd.row]) + qs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++)
            x0_ff[i] <= '0;
      end else if (cmd.accept && req_func == ssrk_pkg::FUNC_LOAD_STATE
                   && 32'(req_address) < NS) begin
         x0_ff[req_address[ssrk_pkg::ROW_W-1:0]] <= req_value;
      end else if (cmd.x_commit) begin
         for (int i = 0; i < NS; i++)
            if (i < 32'(status.nx))
               x0_ff[i] <= sat32(64'(x0_ff[i]) + 64'(ks_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         u_ff[0] <= req_u_zero;
         u_ff[1] <= req_u_one;
         u_ff[2] <= req_u_two;
         u_ff[3] <= req_u_three;
         for (int i = 0; i < NS; i++)
            xs_ff[i] <= x0_ff[i];
      end else if (cmd.xs_copy) begin
         for (int i = 0; i < NS; i++)
            xs_ff[i] <= xn_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.rsp_load)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
      if (cmd.rsp_load) begin
         rsp_index_ff <= cmd.row[1:0];
         rsp_value_ff <= d_sat;
         rsp_last_ff  <= cmd.rsp_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_last  = rsp_last_ff;

endmodule

// File: rtl/state_space_rk4_integrator_core.sv
// Linear state-space engine: x' = A x + B u, y = C x + D u, Q16.16 words.
// Request channel (req_*): one beat is one command chosen by req_func:
//   load a coefficient word, load a state element, compute outputs y,
//   or advance x by one fourth-order Runge-Kutta step of size h.
// Result channel (rsp_*): only output commands produce beats, one per
//   output element, rsp_out_last marking the final one.
// CSR port: plain writes of the size registers and step size; write only
//   while the core is idle and all results have been taken.
// Operation: a load is written as it is taken and leaves the core idle.
//   Every row of a matrix-vector product feeds its nx+ni terms through the
//   single multiply-accumulate unit and then drains the MAC pipeline; an
//   output row then loads its result, a Runge-Kutta row scales by h and updates k.
//   The single MAC unit sets the pace of both compute commands.
// Reset: sizes return to 1, h to 655 (about 0.01), state vector clears;
//   the coefficient store holds garbage until loaded.
// A stalled result beat holds; the core waits with the next output row
//   until the held beat is taken, and takes no new request meanwhile.
module state_space_rk4_integrator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [7:0]         req_address,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_u_zero,
   input  logic signed [31:0] req_u_one,
   input  logic signed [31:0] req_u_two,
   input  logic signed [31:0] req_u_three,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_out_index,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_out_last,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_data
);

   // command and status between sequencer and datapath
   ssrk_pkg::dp_cmd_type    cmd;
   ssrk_pkg::dp_status_type status;

   // sequencer: walks rows, terms and RK stages
   ssrk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: coefficient store, state registers, MAC, result register
   ssrk_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_func      (req_func),
      .req_address   (req_address),
      .req_value     (req_value),
      .req_u_zero    (req_u_zero),
      .req_u_one     (req_u_one),
      .req_u_two     (req_u_two),
      .req_u_three   (req_u_three),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_index (rsp_out_index),
      .rsp_out_value (rsp_out_value),
      .rsp_out_last  (rsp_out_last)
   );

endmodule

// File: rtl/ssrk_checker.sv
module ssrk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_func,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_out_index,
   input logic [31:0] rsp_out_value,
   input logic        rsp_out_last
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_value)
                                  && $stable(rsp_out_index))
      else $error("stalled result beat changed");

   a_busy_after_run: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall
      && (req_func == ssrk_pkg::FUNC_OUTPUT || req_func == ssrk_pkg::FUNC_STEP)
      |=> req_stall)
      else $error("core not busy after compute command");

   a_top_index_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_index == 2'd3 |-> rsp_out_last)
      else $error("highest output index not marked last");

endmodule

bind state_space_rk4_integrator_core ssrk_checker u_ssrk_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_func      (req_func),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_index (rsp_out_index),
   .rsp_out_value (rsp_out_value),
   .rsp_out_last  (rsp_out_last)
);
